### design/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Concurrent assertion helpers shared by the console RTL. Defining ASSERT_OFF
// turns every check into an empty statement.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef ASSERT_OFF

// Clocked check that is skipped while reset is high.
`define TCW_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds while reset is high.
`define TCW_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCW_ASSERT(name, clk, rst, prop, msg)
`define TCW_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, action and register codes, character codes and the request
// type of the shared address unit.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int ACT_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = CHAR_W + ATTR_W;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int COLOR_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Width of row * columns + column for the widest row and column fields.
   localparam int SUM_W = ROW_W + COL_W + 1;

   localparam int MAX_COLS_DEF = 80;
   localparam int MAX_ROWS_DEF = 25;

   localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS       = 2'd3;

   localparam logic [COLOR_W-1:0] BACKGROUND_RST = 4'h0;
   localparam logic [COLOR_W-1:0] FOREGROUND_RST = 4'h7;
   localparam logic [COL_W-1:0]   COLUMNS_RST    = 7'd80;
   localparam logic [ROW_W-1:0]   ROWS_RST       = 5'd25;

   localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NL  = 8'h0A;
   localparam int                TAB_STOP = 8;

   // Request to the shared address unit: result is mul_a * columns + add_b.
   typedef struct packed {
      logic             load;
      logic [ROW_W-1:0] mul_a;
      logic [COL_W-1:0] add_b;
   } addr_req_type;

endpackage

### design/tcw_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tcw_addr_unit.sv
// ----------------------------------------------------------------------------
// Text console address unit
// Shared multiply-add that turns a row and column into a linear cell index.
// ----------------------------------------------------------------------------
module tcw_addr_unit (
   input  logic                      clock,
   input  tcw_pkg::addr_req_type     req,
   input  logic [tcw_pkg::COL_W-1:0] cols,
   output logic [tcw_pkg::SUM_W-1:0] addr
);

   logic [tcw_pkg::SUM_W-1:0] addr_ff;
   logic [tcw_pkg::SUM_W-1:0] addr_in;

   // The row times the row length, plus the offset inside the row.
   assign addr_in = tcw_pkg::SUM_W'(req.mul_a) * tcw_pkg::SUM_W'(cols)
                  + tcw_pkg::SUM_W'(req.add_b);

   always_ff @(posedge clock) begin
      if (req.load) begin
         addr_ff <= addr_in;
      end
   end

   assign addr = addr_ff;

endmodule

### design/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console engine with cursor, wrap, scroll, clear and read-back.
// ----------------------------------------------------------------------------
// The block holds a MAX_COLS * MAX_ROWS screen of 16-bit cells (character in
// the low byte, attribute in the high byte) in one RAM, stored row by row with
// the configured column count as row length, plus a cursor. Each request
// transaction produces exactly one response transaction carrying the cursor
// after the action and, for a read, the cell contents. Transactions are
// handled one at a time under a small sequencer that shares a single
// multiply-add unit for the read and cursor cell indices and the scroll size.
// A read steps through the address, execute, read-wait and done states, a
// put through address, execute and done, and a put that runs past the last
// row adds a scroll, one cell moved per cycle through the RAM's single write
// port. A clear sweeps the whole store before its done state. After reset the
// block sweeps the whole RAM to zero before it accepts its first request;
// register writes are taken at any time. A finished response waits in an
// output register, so the next request may be accepted before it is taken.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           csr_wr_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_data,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tcw_pkg::ACT_W-1:0]      req_action,
   input  logic [tcw_pkg::CHAR_W-1:0]     req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]      req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]      req_read_col,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tcw_pkg::CHAR_W-1:0]     rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]     rsp_cell_attr,
   output logic [tcw_pkg::COL_W-1:0]      rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]      rsp_cursor_row
);

`include "text_console_writer_assert.svh"

   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW    = $clog2(CELLS + 1);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_INIT   = 4'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 4'd1;
   localparam logic [ST_W-1:0] ST_ADDR   = 4'd2;
   localparam logic [ST_W-1:0] ST_EXEC   = 4'd3;
   localparam logic [ST_W-1:0] ST_RDWAIT = 4'd4;
   localparam logic [ST_W-1:0] ST_SCROLL = 4'd5;
   localparam logic [ST_W-1:0] ST_CLEAR  = 4'd6;
   localparam logic [ST_W-1:0] ST_DONE   = 4'd7;

   // Configuration registers.
   logic [tcw_pkg::COLOR_W-1:0] bg_ff;
   logic [tcw_pkg::COLOR_W-1:0] fg_ff;
   logic [tcw_pkg::COL_W-1:0]   columns_ff;
   logic [tcw_pkg::ROW_W-1:0]   rows_ff;

   // Sequencer and transaction state.
   logic [ST_W-1:0]             state_ff, state_in;
   logic [tcw_pkg::ACT_W-1:0]   act_ff, act_in;
   logic [tcw_pkg::CHAR_W-1:0]  char_ff, char_in;
   logic [tcw_pkg::ROW_W-1:0]   rd_row_ff, rd_row_in;
   logic [tcw_pkg::COL_W-1:0]   rd_col_ff, rd_col_in;
   logic [tcw_pkg::COL_W-1:0]   cursor_col_ff, cursor_col_in;
   logic [tcw_pkg::ROW_W-1:0]   cursor_row_ff, cursor_row_in;
   logic [tcw_pkg::CELL_W-1:0]  cell_ff, cell_in;
   logic [CW-1:0]               sweep_ff, sweep_in;
   logic                        pend_ff, pend_in;
   logic [AW-1:0]               pend_addr_ff, pend_addr_in;
   logic                        pend_copy_ff, pend_copy_in;

   // Response register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;
   logic [tcw_pkg::COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::ROW_W-1:0]   rsp_row_ff, rsp_row_in;

   // Effective geometry.
   logic [tcw_pkg::COL_W-1:0]   nc_eff;
   logic [tcw_pkg::ROW_W-1:0]   nr_eff;
   logic [tcw_pkg::ROW_W-1:0]   nr_last;

   // Shared address unit.
   tcw_pkg::addr_req_type       au_req;
   logic [tcw_pkg::SUM_W-1:0]   au_addr;

   // RAM ports.
   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [tcw_pkg::CELL_W-1:0]  ram_wr_data;
   logic                        ram_rd_en;
   logic [AW-1:0]               ram_rd_addr;
   logic [tcw_pkg::CELL_W-1:0]  ram_rd_data;

   // Cursor step for a put.
   logic                        is_tab, is_nl, is_printable;
   logic [tcw_pkg::COL_W:0]     col_step;
   logic [tcw_pkg::ROW_W:0]     row_step;
   logic                        scroll_need;
   logic                        cursor_inside;
   logic                        read_inside;
   logic [CW-1:0]               keep_cnt;
   logic [CW-1:0]               total_cnt;
   logic                        req_fire;

   // ------------------------------------------------------------------------
   // Geometry: a zero count acts as one, a count above the screen store
   // saturates to the store's size.
   // ------------------------------------------------------------------------
   always_comb begin
      priority if (columns_ff == '0) begin
         nc_eff = tcw_pkg::COL_W'(1);
      end else if (32'(columns_ff) > 32'(MAX_COLS)) begin
         nc_eff = tcw_pkg::COL_W'(MAX_COLS);
      end else begin
         nc_eff = columns_ff;
      end
      priority if (rows_ff == '0) begin
         nr_eff = tcw_pkg::ROW_W'(1);
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         nr_eff = tcw_pkg::ROW_W'(MAX_ROWS);
      end else begin
         nr_eff = rows_ff;
      end
   end

   assign nr_last = nr_eff - tcw_pkg::ROW_W'(1);

   // ------------------------------------------------------------------------
   // Configuration writes.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff      <= tcw_pkg::BACKGROUND_RST;
         fg_ff      <= tcw_pkg::FOREGROUND_RST;
         columns_ff <= tcw_pkg::COLUMNS_RST;
         rows_ff    <= tcw_pkg::ROWS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tcw_pkg::CSR_BACKGROUND: bg_ff      <= csr_data[tcw_pkg::COLOR_W-1:0];
            tcw_pkg::CSR_FOREGROUND: fg_ff      <= csr_data[tcw_pkg::COLOR_W-1:0];
            tcw_pkg::CSR_COLUMNS:    columns_ff <= csr_data[tcw_pkg::COL_W-1:0];
            tcw_pkg::CSR_ROWS:       rows_ff    <= csr_data[tcw_pkg::ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Cursor step for a put. The column is one bit wider so that a tab from
   // the far right is seen to pass the last column; the row is one bit wider
   // so that a step past row 31 still reads as beyond the screen.
   // ------------------------------------------------------------------------
   always_comb begin
      is_tab       = (char_ff == tcw_pkg::CHAR_TAB);
      is_nl        = (char_ff == tcw_pkg::CHAR_NL);
      is_printable = !is_tab && !is_nl;
      col_step     = {1'b0, cursor_col_ff};
      row_step     = {1'b0, cursor_row_ff};
      if (is_tab) begin
         col_step = (col_step + (tcw_pkg::COL_W + 1)'(tcw_pkg::TAB_STOP))
                  & ~(tcw_pkg::COL_W + 1)'(tcw_pkg::TAB_STOP - 1);
      end else if (is_nl) begin
         col_step = '0;
         row_step = row_step + (tcw_pkg::ROW_W + 1)'(1);
      end else begin
         col_step = col_step + (tcw_pkg::COL_W + 1)'(1);
      end
      if (col_step >= {1'b0, nc_eff}) begin
         col_step = '0;
         row_step = row_step + (tcw_pkg::ROW_W + 1)'(1);
      end
      scroll_need   = (row_step >= {1'b0, nr_eff});
      cursor_inside = (cursor_col_ff < nc_eff) && (cursor_row_ff < nr_eff);
   end

   assign read_inside = (rd_row_ff < nr_eff) && (rd_col_ff < nc_eff);

   // During a scroll the address unit holds columns * (rows - 1), the number
   // of cells that move up; the rest of the screen is blanked.
   assign keep_cnt  = CW'(au_addr);
   assign total_cnt = keep_cnt + CW'(nc_eff);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // ------------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      char_in       = char_ff;
      rd_row_in     = rd_row_ff;
      rd_col_in     = rd_col_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      cell_in       = cell_ff;
      sweep_in      = sweep_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_copy_in  = pend_copy_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_cell_in   = rsp_cell_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;

      au_req        = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            // One cell zeroed per cycle over the whole store.
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff[AW-1:0];
            sweep_in    = sweep_ff + CW'(1);
            if (sweep_ff == CW'(CELLS - 1)) begin
               sweep_in = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               act_in    = req_action;
               char_in   = req_char_code;
               rd_row_in = req_read_row;
               rd_col_in = req_read_col;
               cell_in   = '0;
               sweep_in  = '0;
               priority if (req_action == tcw_pkg::ACT_PUT ||
                            req_action == tcw_pkg::ACT_READ) begin
                  state_in = ST_ADDR;
               end else if (req_action == tcw_pkg::ACT_CLEAR) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_ADDR: begin
            // Linear index of the cell to read or of the cursor cell.
            au_req.load = 1'b1;
            if (act_ff == tcw_pkg::ACT_READ) begin
               au_req.mul_a = rd_row_ff;
               au_req.add_b = rd_col_ff;
            end else begin
               au_req.mul_a = cursor_row_ff;
               au_req.add_b = cursor_col_ff;
            end
            state_in = ST_EXEC;
         end

         ST_EXEC: begin
            if (act_ff == tcw_pkg::ACT_READ) begin
               ram_rd_en   = read_inside;
               ram_rd_addr = AW'(au_addr);
               state_in    = ST_RDWAIT;
            end else if (char_ff == tcw_pkg::CHAR_NUL) begin
               state_in = ST_DONE;
            end else begin
               ram_wr_en     = is_printable && cursor_inside;
               ram_wr_addr   = AW'(au_addr);
               ram_wr_data   = {bg_ff, fg_ff, char_ff};
               cursor_col_in = col_step[tcw_pkg::COL_W-1:0];
               cursor_row_in = scroll_need ? nr_last : row_step[tcw_pkg::ROW_W-1:0];
               // The cell index has been used above; the unit now sizes the
               // scroll, ready in the next cycle.
               au_req.load  = 1'b1;
               au_req.mul_a = nr_last;
               au_req.add_b = '0;
               state_in     = scroll_need ? ST_SCROLL : ST_DONE;
            end
         end

         ST_RDWAIT: begin
            cell_in  = read_inside ? ram_rd_data : '0;
            state_in = ST_DONE;
         end

         ST_SCROLL: begin
            // Cell i takes the cell one row below it, read in the cycle before the
            // write; cells of the bottom row are written with zero.
            if (sweep_ff < total_cnt) begin
               pend_in      = 1'b1;
               pend_addr_in = sweep_ff[AW-1:0];
               pend_copy_in = (sweep_ff < keep_cnt);
               ram_rd_en    = (sweep_ff < keep_cnt);
               ram_rd_addr  = AW'(sweep_ff + CW'(nc_eff));
               sweep_in     = sweep_ff + CW'(1);
            end else begin
               sweep_in = '0;
               state_in = ST_DONE;
            end
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pend_addr_ff;
               ram_wr_data = pend_copy_ff ? ram_rd_data : '0;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = cell_ff;
               rsp_col_in   = cursor_col_ff;
               rsp_row_in   = cursor_row_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         sweep_ff      <= '0;
         pend_ff       <= 1'b0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         pend_ff       <= pend_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      char_ff      <= char_in;
      rd_row_ff    <= rd_row_in;
      rd_col_ff    <= rd_col_in;
      cell_ff      <= cell_in;
      pend_addr_ff <= pend_addr_in;
      pend_copy_ff <= pend_copy_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
   end

   // ------------------------------------------------------------------------
   // Shared address unit and screen store.
   // ------------------------------------------------------------------------
   tcw_addr_unit u_addr_unit (
      .clock (clock),
      .req   (au_req),
      .cols  (nc_eff),
      .addr  (au_addr)
   );

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_cell_ff[tcw_pkg::CHAR_W-1:0];
   assign rsp_cell_attr  = rsp_cell_ff[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // Reset always restarts the clearing sweep of the screen store.
   `TCW_ASSERT_ALWAYS(a_reset_sweeps, clock, reset |=> state_ff == ST_INIT, "reset did not start the clearing sweep")

   // The delayed scroll write is live only while scrolling.
   `TCW_ASSERT(a_pend_in_scroll, clock, reset, pend_ff |-> state_ff == ST_SCROLL, "scroll write pending outside a scroll")

   // A put that runs off the bottom leaves the cursor on the last row.
   `TCW_ASSERT(a_scroll_cursor, clock, reset, (state_ff == ST_EXEC && act_ff == tcw_pkg::ACT_PUT && char_ff != tcw_pkg::CHAR_NUL && scroll_need) |=> cursor_row_ff == nr_last, "cursor not on the last row after a scroll")

   // A finished result never overwrites one that is still waiting.
   `TCW_ASSERT(a_done_holds, clock, reset, (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_DONE, "result loaded over a waiting response")

endmodule

### tb/sv/text_console_writer_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer checker
// Watches the register port and both channels of the console engine. It keeps
// its own copy of the screen, cursor and colors, predicts the response of
// every accepted request and compares each response, field by field, with the
// oldest prediction. Failures are counted and handed to the test top.
// ----------------------------------------------------------------------------
module text_console_writer_check #(
   parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           csr_wr_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_data,

   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [tcw_pkg::ACT_W-1:0]      req_action,
   input  logic [tcw_pkg::CHAR_W-1:0]     req_char_code,
   input  logic [tcw_pkg::ROW_W-1:0]      req_read_row,
   input  logic [tcw_pkg::COL_W-1:0]      req_read_col,

   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [tcw_pkg::CHAR_W-1:0]     rsp_cell_char,
   input  logic [tcw_pkg::ATTR_W-1:0]     rsp_cell_attr,
   input  logic [tcw_pkg::COL_W-1:0]      rsp_cursor_col,
   input  logic [tcw_pkg::ROW_W-1:0]      rsp_cursor_row,

   output int                             error_count,
   output int                             pending_count,
   output int                             reply_count
);

   import tcw_pkg::*;

   localparam int SCREEN_CELLS = MAX_COLS * MAX_ROWS;

   typedef struct packed {
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
   } console_reply_type;

   logic [CELL_W-1:0]  screen [SCREEN_CELLS];
   logic [COL_W-1:0]   cursor_col;
   logic [ROW_W-1:0]   cursor_row;
   logic [COLOR_W-1:0] background;
   logic [COLOR_W-1:0] foreground;
   logic [COL_W-1:0]   columns_reg;
   logic [ROW_W-1:0]   rows_reg;

   console_reply_type  expected_replies [$];
   console_reply_type  got_reply;
   console_reply_type  want_reply;

   // Register values outside the legal range clamp to the nearest legal size.
   function automatic int active_columns();
      if (columns_reg == '0) return 1;
      if (int'(columns_reg) > MAX_COLS) return MAX_COLS;
      return int'(columns_reg);
   endfunction

   function automatic int active_rows();
      if (rows_reg == '0) return 1;
      if (int'(rows_reg) > MAX_ROWS) return MAX_ROWS;
      return int'(rows_reg);
   endfunction

   function automatic void blank_screen();
      for (int i = 0; i < SCREEN_CELLS; i++) screen[i] = '0;
   endfunction

   function automatic void scroll_screen(input int nc, input int nr);
      for (int i = 0; i < nc * (nr - 1); i++) screen[i] = screen[i + nc];
      for (int i = nc * (nr - 1); i < nc * nr; i++) screen[i] = '0;
   endfunction

   function automatic void put_character(input logic [CHAR_W-1:0] ch);
      int nc;
      int nr;
      int col;
      int row;
      nc  = active_columns();
      nr  = active_rows();
      col = int'(cursor_col);
      row = int'(cursor_row);
      // A NUL character leaves everything untouched, wrap check included.
      if (ch == CHAR_NUL) return;
      if (ch == CHAR_TAB) begin
         col = (col + TAB_STOP) & ~(TAB_STOP - 1);
      end else if (ch == CHAR_NL) begin
         col = 0;
         row = row + 1;
      end else begin
         // A cursor left outside a shrunken screen skips the write only.
         if (col < nc && row < nr) begin
            screen[row * nc + col] = {background, foreground, ch};
         end
         col = col + 1;
      end
      if (col >= nc) begin
         col = 0;
         row = row + 1;
      end
      if (row >= nr) begin
         row = nr - 1;
         scroll_screen(nc, nr);
      end
      cursor_col = col[COL_W-1:0];
      cursor_row = row[ROW_W-1:0];
   endfunction

   function automatic console_reply_type predict_reply(
      input logic [ACT_W-1:0]  act,
      input logic [CHAR_W-1:0] ch,
      input logic [ROW_W-1:0]  rr,
      input logic [COL_W-1:0]  rc
   );
      console_reply_type reply;
      logic [CELL_W-1:0] cell_word;
      cell_word = '0;
      case (act)
         ACT_PUT: begin
            put_character(ch);
         end
         ACT_READ: begin
            if (int'(rr) < active_rows() && int'(rc) < active_columns()) begin
               cell_word = screen[int'(rr) * active_columns() + int'(rc)];
            end
         end
         ACT_CLEAR: begin
            blank_screen();
         end
         default: begin
         end
      endcase
      reply.cell_char  = cell_word[CHAR_W-1:0];
      reply.cell_attr  = cell_word[CELL_W-1:CHAR_W];
      reply.cursor_col = cursor_col;
      reply.cursor_row = cursor_row;
      return reply;
   endfunction

   function automatic void note_failure(input string what);
      error_count++;
      if (error_count <= 10) $display("[%0t] %s", $time, what);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         blank_screen();
         cursor_col  = '0;
         cursor_row  = '0;
         background  = BACKGROUND_RST;
         foreground  = FOREGROUND_RST;
         columns_reg = COLUMNS_RST;
         rows_reg    = ROWS_RST;
         expected_replies.delete();
         error_count = 0;
         reply_count = 0;
      end else begin
         // Responses are matched before new requests are queued, so a response
         // can never be paired with a request taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            got_reply = {rsp_cell_char, rsp_cell_attr, rsp_cursor_col, rsp_cursor_row};
            reply_count++;
            if (expected_replies.size() == 0) begin
               note_failure($sformatf({"response with nothing outstanding: ",
                  "char %02h attr %02h cursor %0d,%0d"},
                  got_reply.cell_char, got_reply.cell_attr,
                  got_reply.cursor_row, got_reply.cursor_col));
            end else begin
               want_reply = expected_replies.pop_front();
               if (got_reply.cell_char  !== want_reply.cell_char  ||
                   got_reply.cell_attr  !== want_reply.cell_attr  ||
                   got_reply.cursor_col !== want_reply.cursor_col ||
                   got_reply.cursor_row !== want_reply.cursor_row) begin
                  note_failure($sformatf({"response mismatch: expected char %02h attr %02h ",
                     "cursor %0d,%0d, got char %02h attr %02h cursor %0d,%0d"},
                     want_reply.cell_char, want_reply.cell_attr,
                     want_reply.cursor_row, want_reply.cursor_col,
                     got_reply.cell_char, got_reply.cell_attr,
                     got_reply.cursor_row, got_reply.cursor_col));
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BACKGROUND: background  = csr_data[COLOR_W-1:0];
               CSR_FOREGROUND: foreground  = csr_data[COLOR_W-1:0];
               CSR_COLUMNS:    columns_reg = csr_data[COL_W-1:0];
               CSR_ROWS:       rows_reg    = csr_data[ROW_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            expected_replies.push_back(predict_reply(req_action, req_char_code,
                                                     req_read_row, req_read_col));
         end
      end
      pending_count = expected_replies.size();
   end

endmodule

### tb/sv/text_console_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer test
// Drives the console engine through a directed opening and then random put,
// read, clear and unused traffic over many screen geometries and colors, with
// random idle cycles on both channels. A checker beside the block predicts
// every response; this top only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module text_console_writer_test;

   import tcw_pkg::*;

   localparam int MAX_COLS = MAX_COLS_DEF;
   localparam int MAX_ROWS = MAX_ROWS_DEF;

   // The action field has one code with no defined operation.
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [CSR_DATA_W-1:0] csr_data      = '0;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic [ACT_W-1:0]      req_action    = '0;
   logic [CHAR_W-1:0]     req_char_code = '0;
   logic [ROW_W-1:0]      req_read_row  = '0;
   logic [COL_W-1:0]      req_read_col  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [CHAR_W-1:0]     rsp_cell_char;
   logic [ATTR_W-1:0]     rsp_cell_attr;
   logic [COL_W-1:0]      rsp_cursor_col;
   logic [ROW_W-1:0]      rsp_cursor_row;

   int error_count;
   int pending_count;
   int reply_count;

   // While steady is set neither side inserts idle cycles.
   bit steady = 1'b0;

   // Active screen size as the block sees it, used to aim most reads inside.
   int screen_cols = MAX_COLS;
   int screen_rows = MAX_ROWS;

   int puts_sent;
   int reads_sent;
   int clears_sent;
   int unused_sent;
   int geometries;

   text_console_writer #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row)
   );

   text_console_writer_check #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_check (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .error_count    (error_count),
      .pending_count  (pending_count),
      .reply_count    (reply_count)
   );

   // 12 ns clock period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The response side stalls at random with a chance of about 6 percent. A fresh draw is
   // made every cycle, so stalls land on every stage of the block's work.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 6);
   end

   // Safety net for a hung block. The slowest legal run, with every
   // transaction scrolling or clearing the full screen, stays well under this.
   initial begin
      #200ms;
      $display("text_console_writer_test NOT OK");
      $finish;
   end

   // Drops valid and waits until the checker has seen every response, then
   // lets the clock run on with valid low so the sequencer is back at rest.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all four registers, one per cycle, once the block is idle. Every
   // phase goes through here, so each register is written many times.
   task automatic program_screen(
      input logic [COLOR_W-1:0] bg,
      input logic [COLOR_W-1:0] fg,
      input logic [COL_W-1:0]   cols,
      input logic [ROW_W-1:0]   rows
   );
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BACKGROUND;
      csr_data  <= CSR_DATA_W'(bg);
      @(posedge clock);
      csr_index <= CSR_FOREGROUND;
      csr_data  <= CSR_DATA_W'(fg);
      @(posedge clock);
      csr_index <= CSR_COLUMNS;
      csr_data  <= CSR_DATA_W'(cols);
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_data  <= CSR_DATA_W'(rows);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      // Zero acts as one, and sizes above the maximum saturate.
      screen_cols = (cols == '0) ? 1 : ((int'(cols) > MAX_COLS) ? MAX_COLS : int'(cols));
      screen_rows = (rows == '0) ? 1 : ((int'(rows) > MAX_ROWS) ? MAX_ROWS : int'(rows));
      geometries++;
   endtask

   // Presents one request transaction and returns at the edge that accepts it.
   // Valid stays high from one transaction to the next unless an idle cycle
   // is drawn, so back-to-back transfers happen whenever the block allows.
   task automatic issue(
      input logic [ACT_W-1:0]  act,
      input logic [CHAR_W-1:0] ch,
      input logic [ROW_W-1:0]  rr,
      input logic [COL_W-1:0]  rc
   );
      if (!steady) begin
         while ($urandom_range(0, 99) < 6) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_char_code <= ch;
      req_read_row  <= rr;
      req_read_col  <= rc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (act)
         ACT_PUT:   puts_sent++;
         ACT_READ:  reads_sent++;
         ACT_CLEAR: clears_sent++;
         default:   unused_sent++;
      endcase
   endtask

   // One random transaction. Puts dominate so the cursor keeps moving through
   // wraps and scrolls; control characters are drawn often enough to matter.
   // Every field is randomized over its full width, even where the action
   // ignores it, and some reads aim outside the active screen.
   task automatic random_request();
      int                pick;
      logic [ACT_W-1:0]  act;
      logic [CHAR_W-1:0] ch;
      logic [ROW_W-1:0]  rr;
      logic [COL_W-1:0]  rc;
      pick = $urandom_range(0, 99);
      ch   = CHAR_W'($urandom_range(0, 255));
      rr   = ROW_W'($urandom_range(0, 31));
      rc   = COL_W'($urandom_range(0, 127));
      if (pick < 3) begin
         act = ACT_CLEAR;
      end else if (pick < 5) begin
         act = ACT_UNUSED;
      end else if (pick < 27) begin
         act = ACT_READ;
         if ($urandom_range(0, 99) < 85) begin
            rr = ROW_W'($urandom_range(0, screen_rows - 1));
            rc = COL_W'($urandom_range(0, screen_cols - 1));
         end
      end else begin
         act  = ACT_PUT;
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            ch = CHAR_NL;
         end else if (pick < 16) begin
            ch = CHAR_TAB;
         end else if (pick < 19) begin
            ch = CHAR_NUL;
         end
      end
      issue(act, ch, rr, rc);
   endtask

   // A phase sets colors and geometry, then sends random traffic. Now and
   // then the sender holds off until every response is back.
   task automatic run_phase(
      input logic [COLOR_W-1:0] bg,
      input logic [COLOR_W-1:0] fg,
      input logic [COL_W-1:0]   cols,
      input logic [ROW_W-1:0]   rows,
      input int                 count,
      input bit                 quiet
   );
      program_screen(bg, fg, cols, rows);
      steady = quiet;
      repeat (count) begin
         random_request();
         if (!steady && $urandom_range(0, 99) == 0) settle();
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed opening on the full screen with extreme colors. The block
      // clears its memory after reset, so the first read must come back zero.
      program_screen(4'hF, 4'h0, 7'd80, 5'd25);
      issue(ACT_READ, 8'h00, 5'd0, 7'd0);
      issue(ACT_PUT, 8'h41, 5'd0, 7'd0);
      issue(ACT_PUT, 8'hFF, 5'd31, 7'd127);
      issue(ACT_PUT, CHAR_NUL, 5'd0, 7'd0);
      issue(ACT_PUT, CHAR_TAB, 5'd0, 7'd0);
      issue(ACT_PUT, 8'h80, 5'd0, 7'd0);
      issue(ACT_PUT, CHAR_NL, 5'd0, 7'd0);
      issue(ACT_READ, 8'h00, 5'd0, 7'd0);
      issue(ACT_READ, 8'hFF, 5'd0, 7'd1);
      issue(ACT_READ, 8'h00, 5'd0, 7'd8);
      issue(ACT_READ, 8'h00, 5'd24, 7'd79);
      // Reads past the last row or column return zero.
      issue(ACT_READ, 8'h00, 5'd31, 7'd127);
      issue(ACT_READ, 8'h00, 5'd25, 7'd0);
      issue(ACT_READ, 8'h00, 5'd0, 7'd80);
      issue(ACT_UNUSED, 8'h41, 5'd0, 7'd0);
      issue(ACT_CLEAR, 8'h00, 5'd0, 7'd0);
      issue(ACT_READ, 8'h00, 5'd0, 7'd0);

      // Zero-sized registers act as a one-cell screen. The cursor now sits
      // below it, so the next put skips its write but still wraps and scrolls.
      program_screen(4'h0, 4'hF, 7'd0, 5'd0);
      issue(ACT_PUT, 8'h41, 5'd0, 7'd0);
      issue(ACT_READ, 8'h00, 5'd0, 7'd0);
      issue(ACT_PUT, CHAR_TAB, 5'd0, 7'd0);
      issue(ACT_PUT, CHAR_NL, 5'd0, 7'd0);

      // Register values above the maximum saturate to the full screen.
      program_screen(4'h5, 4'hA, 7'd127, 5'd31);
      issue(ACT_PUT, 8'h5A, 5'd0, 7'd0);
      issue(ACT_READ, 8'h00, 5'd0, 7'd0);
      issue(ACT_READ, 8'h00, 5'd24, 7'd79);

      // Random traffic. Small screens carry most of it since every scroll on a large one
      // costs a full pass over the memory; a clear costs a full pass on any screen.
      run_phase(4'h3, 4'hC, 7'd8, 5'd4, 150, 1'b0);
      run_phase(4'h0, 4'h7, 7'd3, 5'd2, 120, 1'b0);
      run_phase(4'hF, 4'hF, 7'd80, 5'd25, 80, 1'b0);
      run_phase(4'h9, 4'h1, 7'd17, 5'd5, 150, 1'b1);
      run_phase(4'h6, 4'h6, 7'd1, 5'd1, 60, 1'b0);
      run_phase(4'h2, 4'hD, 7'd40, 5'd3, 150, 1'b0);
      run_phase(4'hB, 4'h4, 7'd0, 5'd0, 40, 1'b0);
      run_phase(4'hE, 4'h8, 7'd127, 5'd31, 50, 1'b0);
      run_phase(4'h7, 4'h2, 7'd12, 5'd25, 130, 1'b0);
      run_phase(4'h1, 4'hA, 7'd80, 5'd1, 100, 1'b0);
      run_phase(4'h4, 4'h5, 7'd9, 5'd7, 95, 1'b0);

      // Drain, then give any stray response time to show up.
      settle();
      repeat (40) @(posedge clock);

      $display({"Sent %0d transactions (%0d puts, %0d reads, %0d clears, %0d unused) ",
                "over %0d geometries."},
               puts_sent + reads_sent + clears_sent + unused_sent,
               puts_sent, reads_sent, clears_sent, unused_sent, geometries);
      $display("Compared %0d responses against the predicted screen and cursor.", reply_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("text_console_writer_test OK");
      end else begin
         $display("text_console_writer_test NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_addr_unit.sv
design/text_console_writer.sv
tb/sv/text_console_writer_check.sv
tb/sv/text_console_writer_test.sv
